// ----- rtl/core/aes_gcm_authenticated_cipher_macros.svh -----
// Assertion macros shared by the AES-GCM engine modules.
`ifndef AES_GCM_AUTHENTICATED_CIPHER_MACROS_SVH
`define AES_GCM_AUTHENTICATED_CIPHER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define AGC_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define AGC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/core/agc_pkg.sv -----
// Shared types, constants and functions of the AES-GCM engine.
`timescale 1ns / 1ps
package agc_pkg;

    localparam int ROUND_COUNT_DEF = 10;
    localparam int BLK_W = 128;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_AAD   = 2'd1;
    localparam logic [1:0] ACT_TEXT  = 2'd2;
    localparam logic [1:0] ACT_FIN   = 2'd3;

    localparam logic [7:0] GF_POLY = 8'h1b;
    localparam logic [7:0] GH_POLY = 8'he1;

    // Classified item handed from front to back.
    typedef struct packed {
        logic [1:0]   act;
        logic [127:0] data;
        logic [4:0]   nbytes;
        logic         dir;
        logic [127:0] key;
    } t_cmd;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8].
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[c*4+i] = sbox(s[127 - 8*(((c+i)%4)*4+i) -: 8]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (last) begin
                o[127-32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                o[127-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                     a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
            end
        end
        return o;
    endfunction

    // Next round key from the previous one.
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        {w0, w1, w2, w3} = k;
        t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] lead_mask(input logic [4:0] n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++) begin
            m[127-8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/aes_gcm_authenticated_cipher.sv -----
// Top level of the AES-128-GCM engine.
//
// Input channel i_valid/o_ready carries action, data and byte_count;
// output channel o_valid/i_ready: one result per text or finish not dropped.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 key upper, 1 key lower, 2 direction); the user must write only while
// the block is idle, which the block itself does not enforce. Items pass
// through a two-entry queue into a sequencer with one AES round unit
// (one round a cycle) and an 8-bit-digit GHASH multiplier. Sequencer steps
// per item: start (accept, key expansion, two encryptions), AAD and finish
// (accept, GHASH), text (accept, AES rounds, keystream XOR, GHASH).
// Dropped items are only accepted and take no further step.
// The result is written to the output register on the last GHASH cycle;
// if the receiver stalls, the sequencer waits there, while the queue
// keeps accepting up to two items.
// Reset (synchronous, active low) clears the phase, hash state, queue
// and output valid; key registers return to zero.
`timescale 1ns / 1ps
module aes_gcm_authenticated_cipher #(
    parameter int ROUND_COUNT = agc_pkg::ROUND_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_data_upper,
    input  logic [63:0] i_data_lower,
    input  logic [4:0]  i_byte_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [63:0] o_out_upper,
    output logic [63:0] o_out_lower,
    output logic [4:0]  o_out_bytes,
    output logic        o_tag_match
);
    localparam logic [1:0] REG_KEY_UP = 2'd0;
    localparam logic [1:0] REG_KEY_LO = 2'd1;
    localparam logic [1:0] REG_DIR    = 2'd2;

    logic [63:0]   r_key_up, r_key_lo;
    logic          r_dir;
    logic          w_cv, w_cr;
    agc_pkg::t_cmd w_cmd;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_up <= '0;
            r_key_lo <= '0;
            r_dir    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_UP: r_key_up <= i_cfg_data;
                REG_KEY_LO: r_key_lo <= i_cfg_data;
                REG_DIR:    r_dir    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    agc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_data({i_data_upper, i_data_lower}),
        .i_byte_count(i_byte_count), .i_dir(r_dir), .i_key({r_key_up, r_key_lo}),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    agc_back #(.ROUND_COUNT(ROUND_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cv), .o_cmd_ready(w_cr),
        .i_cmd(w_cmd), .o_valid(o_valid), .i_ready(i_ready),
        .o_result_kind(o_result_kind), .o_out_upper(o_out_upper),
        .o_out_lower(o_out_lower), .o_out_bytes(o_out_bytes), .o_tag_match(o_tag_match)
    );
endmodule

// ----- rtl/core/agc_front.sv -----
// Front end: accepts items and writes them into a short queue.
`timescale 1ns / 1ps
`include "aes_gcm_authenticated_cipher_macros.svh"
module agc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_action,
    input  logic [127:0]        i_data,
    input  logic [4:0]          i_byte_count,
    input  logic                i_dir,
    input  logic [127:0]        i_key,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output agc_pkg::t_cmd       o_cmd
);
    localparam int DEPTH = 2;

    agc_pkg::t_cmd r_q [DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;
    logic [4:0]    w_n;

    assign o_ready     = (r_cnt != 2'(DEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    // Clamp byte count; zero stays zero, and AAD or text items with zero are dropped by the back end.
    assign w_n = (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;

    // Queue storage and pointers.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{act: i_action, data: i_data, nbytes: w_n, dir: i_dir, key: i_key};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    `AGC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_cnt == 2'(DEPTH), !w_push, "queue overflow")
    `AGC_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, w_push && !w_pop, r_cnt != 2'd0, "count lost")
    `AGC_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 2'(DEPTH), "count range")
endmodule

// ----- rtl/core/agc_back.sv -----
// Back end: AES round unit, GHASH digit multiplier and message control.
`timescale 1ns / 1ps
`include "aes_gcm_authenticated_cipher_macros.svh"
module agc_back #(
    parameter int ROUND_COUNT = agc_pkg::ROUND_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  agc_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_result_kind,
    output logic [63:0]    o_out_upper,
    output logic [63:0]    o_out_lower,
    output logic [4:0]     o_out_bytes,
    output logic           o_tag_match
);
    localparam int RKN = ROUND_COUNT + 1;
    localparam int RW  = $clog2(RKN + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_KEXP, S_ENC_H, S_ENC_J, S_ENC_T, S_GH, S_OUT
    } t_state;

    typedef enum logic [1:0] {PH_IDLE, PH_AAD, PH_TEXT, PH_CLOSED} t_phase;

    t_state        r_state;
    t_phase        r_phase;
    logic [127:0]  r_rk [RKN];
    logic [127:0]  r_kcur;
    logic [7:0]    r_rc;
    logic [RW-1:0] r_rnd;
    logic [127:0]  r_s;
    logic [127:0]  r_h, r_tmask, r_ctr, r_acc;
    logic [63:0]   r_alen, r_tlen;
    logic [127:0]  r_x, r_z, r_v;
    logic [4:0]    r_dig;
    agc_pkg::t_cmd r_cmd;
    logic          r_emit;
    logic [127:0]  r_obuf;

    logic [127:0]  w_rk, w_rout, w_mask, w_ks, w_tx, w_cin, w_z, w_v, w_tag;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_rk   = r_rk[r_rnd[$clog2(RKN)-1:0]];
    assign w_rout = agc_pkg::aes_round(r_s, r_rnd == RW'(ROUND_COUNT)) ^ w_rk;
    assign w_mask = agc_pkg::lead_mask(r_cmd.nbytes);
    assign w_ks   = r_s;
    assign w_tx   = (r_cmd.data ^ w_ks) & w_mask;
    assign w_cin  = r_cmd.dir ? (r_cmd.data & w_mask) : w_tx;
    assign w_tag  = r_acc ^ r_tmask;

    // Eight bits of the multiplier operand per cycle, unless the last step is held for a stalled output.
    always_comb begin
        w_z = r_z;
        w_v = r_v;
        for (int i = 0; i < 8; i++) begin
            if (r_x[127-i]) w_z = w_z ^ w_v;
            w_v = {1'b0, w_v[127:1]} ^ (w_v[0] ? {agc_pkg::GH_POLY, 120'd0} : 128'd0);
        end
    end

    // Sequencer, datapath registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_alen  <= '0;
            r_tlen  <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.act)
                            agc_pkg::ACT_START: begin
                                r_kcur  <= i_cmd.key;
                                r_rk[0] <= i_cmd.key;
                                r_rc    <= 8'h01;
                                r_rnd   <= RW'(1);
                                r_state <= S_KEXP;
                            end
                            agc_pkg::ACT_AAD: begin
                                if (r_phase == PH_AAD && i_cmd.nbytes != 5'd0) begin
                                    r_x <= r_acc ^ (i_cmd.data &
                                           agc_pkg::lead_mask(i_cmd.nbytes));
                                    r_z <= '0; r_v <= r_h; r_dig <= '0;
                                    r_alen <= r_alen + 64'({i_cmd.nbytes, 3'b000});
                                    if (i_cmd.nbytes < 5'd16) r_phase <= PH_TEXT;
                                    r_emit <= 1'b0;
                                    r_state <= S_GH;
                                end
                            end
                            agc_pkg::ACT_TEXT: begin
                                if ((r_phase == PH_AAD || r_phase == PH_TEXT) &&
                                    i_cmd.nbytes != 5'd0) begin
                                    r_ctr[31:0] <= r_ctr[31:0] + 32'd1;
                                    r_s <= {r_ctr[127:32], r_ctr[31:0] + 32'd1} ^ r_rk[0];
                                    r_rnd <= RW'(1);
                                    r_state <= S_ENC_T;
                                end
                            end
                            default: begin
                                if (r_phase != PH_IDLE) begin
                                    r_x <= r_acc ^ {r_alen, r_tlen};
                                    r_z <= '0; r_v <= r_h; r_dig <= '0;
                                    r_phase <= PH_IDLE;
                                    r_emit <= 1'b1;
                                    r_state <= S_GH;
                                end
                            end
                        endcase
                    end
                end
                S_KEXP: begin
                    r_kcur <= agc_pkg::key_step(r_kcur, r_rc);
                    r_rk[r_rnd[$clog2(RKN)-1:0]] <= agc_pkg::key_step(r_kcur, r_rc);
                    r_rc <= agc_pkg::xtime(r_rc);
                    if (r_rnd == RW'(ROUND_COUNT)) begin
                        r_s <= r_rk[0];
                        r_rnd <= RW'(1);
                        r_state <= S_ENC_H;
                    end else begin
                        r_rnd <= r_rnd + RW'(1);
                    end
                end
                S_ENC_H, S_ENC_J, S_ENC_T: begin
                    r_s <= w_rout;
                    r_rnd <= r_rnd + RW'(1);
                    if (r_rnd == RW'(ROUND_COUNT)) begin
                        r_rnd <= RW'(1);
                        if (r_state == S_ENC_H) begin
                            r_h <= w_rout;
                            r_ctr <= {r_cmd.data[127:32], 32'd1};
                            r_s <= {r_cmd.data[127:32], 32'd1} ^ r_rk[0];
                            r_state <= S_ENC_J;
                        end else if (r_state == S_ENC_J) begin
                            r_tmask <= w_rout;
                            r_acc <= '0; r_alen <= '0; r_tlen <= '0;
                            r_phase <= PH_AAD;
                            r_state <= S_IDLE;
                        end else begin
                            r_s <= w_rout;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    // r_s holds the keystream for this text item.
                    r_obuf <= w_tx;
                    r_x <= r_acc ^ w_cin;
                    r_z <= '0; r_v <= r_h; r_dig <= '0;
                    r_tlen <= r_tlen + 64'({r_cmd.nbytes, 3'b000});
                    r_phase <= (r_cmd.nbytes < 5'd16) ? PH_CLOSED : PH_TEXT;
                    r_emit <= 1'b1;
                    r_state <= S_GH;
                end
                S_GH: begin
                    r_z <= w_z;
                    r_v <= w_v;
                    r_x <= {r_x[119:0], 8'd0};
                    r_dig <= r_dig + 5'd1;
                    if (r_dig == 5'd15) begin
                        r_acc <= w_z;
                        if (r_emit && !(o_valid && !i_ready)) begin
                            o_valid <= 1'b1;
                            if (r_cmd.act == agc_pkg::ACT_TEXT) begin
                                o_result_kind <= 1'b0;
                                {o_out_upper, o_out_lower} <= r_obuf;
                                o_out_bytes <= r_cmd.nbytes;
                                o_tag_match <= 1'b0;
                            end else begin
                                o_result_kind <= 1'b1;
                                if (r_cmd.dir) begin
                                    {o_out_upper, o_out_lower} <= '0;
                                    o_out_bytes <= 5'd0;
                                    o_tag_match <= ((w_z ^ r_tmask) == r_cmd.data);
                                end else begin
                                    {o_out_upper, o_out_lower} <= w_z ^ r_tmask;
                                    o_out_bytes <= 5'd16;
                                    o_tag_match <= 1'b0;
                                end
                            end
                            r_state <= S_IDLE;
                        end else if (!r_emit) begin
                            r_state <= S_IDLE;
                        end else begin
                            // Hold the last step until the output register frees.
                            r_z <= r_z; r_v <= r_v; r_x <= r_x; r_dig <= r_dig;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_valid && i_ready && !(r_state == S_GH && r_dig == 5'd15 && r_emit)) begin
                o_valid <= 1'b0;
            end
        end
    end

    `AGC_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_cmd_ready, r_state == S_IDLE,
        "ready outside idle")
    `AGC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_out_upper), "stalled result changed")
    `AGC_ASSERT_IMP(a_dig_range, i_clk, i_rst_n, r_state == S_GH, r_dig <= 5'd15,
        "digit count past block")
endmodule

// ----- verif/aes_gcm_authenticated_cipher_test.sv -----
// Self-checking testbench for the AES-128-GCM engine against a local predictor.
`timescale 1ns / 1ps
module aes_gcm_authenticated_cipher_test;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE = 120;
    localparam logic [1:0] REG_KEY_UP = 2'd0;
    localparam logic [1:0] REG_KEY_LO = 2'd1;
    localparam logic [1:0] REG_DIR    = 2'd2;
    localparam logic DIR_SEAL = 1'b0;
    localparam logic DIR_OPEN = 1'b1;
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_TAG  = 1'b1;

    typedef enum logic [1:0] {MSG_IDLE, MSG_AAD, MSG_TEXT, MSG_CLOSED} t_msg_phase;

    typedef struct {
        logic        kind;
        logic [63:0] up;
        logic [63:0] lo;
        logic [4:0]  nbytes;
        logic        match;
    } t_gcm_result;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid, o_ready;
    logic [1:0]  i_action;
    logic [63:0] i_data_upper, i_data_lower;
    logic [4:0]  i_byte_count;
    logic        o_valid, i_ready;
    logic        o_result_kind;
    logic [63:0] o_out_upper, o_out_lower;
    logic [4:0]  o_out_bytes;
    logic        o_tag_match;

    aes_gcm_authenticated_cipher DUT (.*);

    // Forward S-box
    logic [7:0] sub_byte [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    // Predictor copy of configuration and message state
    logic [127:0] cipher_key;
    logic         open_mode;
    logic [127:0] sched_keys [11];
    logic [127:0] hkey, j0_mask, ctr_block, hash_acc;
    logic [63:0]  aad_bits, text_bits;
    t_msg_phase   phase;

    t_gcm_result  pending_results [$];
    int errors, items_sent, results_seen, tags_seen, verdicts_true;
    int cycle_count, hold_left, stall_left;
    bit calm, done;

    // Clock and cycle limit
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] keep_bytes(input int n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++) m[127-8*i -: 8] = (i < n) ? 8'hff : 8'h00;
        return m;
    endfunction

    // Key schedule for the current key
    function automatic void build_round_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int g = 0; g < 4; g++) w[g] = cipher_key[127-32*g -: 32];
        for (int g = 4; g < 44; g++) begin
            t = w[g-1];
            if (g % 4 == 0) begin
                t = {sub_byte[t[23:16]] ^ rc, sub_byte[t[15:8]], sub_byte[t[7:0]],
                     sub_byte[t[31:24]]};
                rc = gf_double(rc);
            end
            w[g] = w[g-4] ^ t;
        end
        for (int r = 0; r < 11; r++) sched_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
        logic [127:0] s;
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        s = blk ^ sched_keys[0];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[c*4+i] = sub_byte[s[127 - 8*(((c+i)%4)*4+i) -: 8]];
            for (int c = 0; c < 4; c++) begin
                a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                if (r < 10)
                    s[127-32*c -: 32] = {a0 ^ al ^ gf_double(a0 ^ a1),
                                         a1 ^ al ^ gf_double(a1 ^ a2),
                                         a2 ^ al ^ gf_double(a2 ^ a3),
                                         a3 ^ al ^ gf_double(a3 ^ a0)};
                else
                    s[127-32*c -: 32] = {a0, a1, a2, a3};
            end
            s = s ^ sched_keys[r];
        end
        return s;
    endfunction

    function automatic logic [127:0] gf128_mul(input logic [127:0] x, input logic [127:0] y);
        logic [127:0] z, v;
        z = '0;
        v = y;
        for (int i = 0; i < 128; i++) begin
            if (x[127-i]) z ^= v;
            v = v[0] ? ((v >> 1) ^ {8'he1, 120'd0}) : (v >> 1);
        end
        return z;
    endfunction

    // Tag the block would give if the message finished now
    function automatic logic [127:0] tag_if_finished();
        return gf128_mul(hash_acc ^ {aad_bits, text_bits}, hkey) ^ j0_mask;
    endfunction

    // Update the predictor with one accepted item; queue any result it causes
    function automatic void predict_gcm(input logic [1:0] act, input logic [127:0] d,
                                        input logic [4:0] raw_n);
        int n;
        logic [127:0] m, ks, txt, tag;
        t_gcm_result r;
        n = (raw_n > 16) ? 16 : int'(raw_n);
        m = keep_bytes(n);
        case (act)
            agc_pkg::ACT_START: begin
                build_round_keys();
                hkey = aes_encrypt('0);
                ctr_block = {d[127:32], 32'd1};
                j0_mask = aes_encrypt(ctr_block);
                hash_acc = '0;
                aad_bits = '0;
                text_bits = '0;
                phase = MSG_AAD;
            end
            agc_pkg::ACT_AAD: begin
                if (phase == MSG_AAD && n != 0) begin
                    hash_acc = gf128_mul(hash_acc ^ (d & m), hkey);
                    aad_bits += 64'(n * 8);
                    if (n < 16) phase = MSG_TEXT;
                end
            end
            agc_pkg::ACT_TEXT: begin
                if ((phase == MSG_AAD || phase == MSG_TEXT) && n != 0) begin
                    ctr_block[31:0] = ctr_block[31:0] + 32'd1;
                    ks = aes_encrypt(ctr_block);
                    txt = (d ^ ks) & m;
                    hash_acc = gf128_mul(hash_acc ^ (open_mode ? (d & m) : txt), hkey);
                    text_bits += 64'(n * 8);
                    phase = (n < 16) ? MSG_CLOSED : MSG_TEXT;
                    r = '{KIND_TEXT, txt[127:64], txt[63:0], 5'(n), 1'b0};
                    pending_results.push_back(r);
                end
            end
            default: begin
                if (phase != MSG_IDLE) begin
                    tag = tag_if_finished();
                    phase = MSG_IDLE;
                    if (open_mode)
                        r = '{KIND_TAG, 64'd0, 64'd0, 5'd0, tag == d};
                    else
                        r = '{KIND_TAG, tag[127:64], tag[63:0], 5'd16, 1'b0};
                    pending_results.push_back(r);
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0d] mismatch on %s: got %h, expected %h", cycle_count, what, got, want);
        errors++;
    endtask

    // Receiver: random stalls, a few long ones, long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 2) begin
            stall_left <= $urandom_range(8, 40);
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_gcm_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_out_upper, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (want.kind == KIND_TAG) tags_seen++;
                if (want.match) verdicts_true++;
                if (o_result_kind !== want.kind)
                    report_mismatch("kind", 64'(o_result_kind), 64'(want.kind));
                if (o_out_upper !== want.up) report_mismatch("out_upper", o_out_upper, want.up);
                if (o_out_lower !== want.lo) report_mismatch("out_lower", o_out_lower, want.lo);
                if (o_out_bytes !== want.nbytes)
                    report_mismatch("out_bytes", 64'(o_out_bytes), 64'(want.nbytes));
                if (o_tag_match !== want.match)
                    report_mismatch("tag_match", 64'(o_tag_match), 64'(want.match));
            end
        end
    end

    function automatic int pick_gap();
        int p;
        if (calm) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one item, wait for acceptance, then predict
    task automatic send_item(input logic [1:0] act, input logic [127:0] d, input logic [4:0] n);
        int gap;
        i_valid <= 1'b1;
        i_action <= act;
        i_data_upper <= d[127:64];
        i_data_lower <= d[63:0];
        i_byte_count <= n;
        do @(posedge i_clk); while (!o_ready);
        predict_gcm(act, d, n);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait for all results, then let dropped or hash-only items finish
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [127:0] key, input logic dir);
        drain();
        write_reg(REG_KEY_UP, key[127:64]);
        write_reg(REG_KEY_LO, key[63:0]);
        write_reg(REG_DIR, {63'd0, dir});
        cipher_key = key;
        open_mode = dir;
    endtask

    function automatic logic [127:0] rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Finish item: on open, carry the correct tag when good_tag is set
    task automatic send_finish(input bit good_tag);
        logic [127:0] d;
        d = rand_block();
        if (open_mode && good_tag && phase != MSG_IDLE) d = tag_if_finished();
        send_item(agc_pkg::ACT_FIN, d, 5'($urandom_range(0, 31)));
    endtask

    // One well-formed message with random content
    task automatic send_message(input int max_full);
        int na, nt;
        send_item(agc_pkg::ACT_START, rand_block(), 5'($urandom_range(0, 31)));
        na = $urandom_range(0, max_full);
        nt = $urandom_range(0, max_full);
        repeat (na) send_item(agc_pkg::ACT_AAD, rand_block(), 5'd16);
        if ($urandom_range(0, 1))
            send_item(agc_pkg::ACT_AAD, rand_block(), 5'($urandom_range(1, 15)));
        repeat (nt) send_item(agc_pkg::ACT_TEXT, rand_block(), 5'd16);
        if ($urandom_range(0, 1))
            send_item(agc_pkg::ACT_TEXT, rand_block(), 5'($urandom_range(1, 15)));
        send_finish($urandom_range(0, 1));
    endtask

    task automatic test_directed();
        set_config({128{1'b0}}, DIR_SEAL);
        // Actions while idle are dropped
        send_item(agc_pkg::ACT_AAD, rand_block(), 5'd16);
        send_item(agc_pkg::ACT_TEXT, rand_block(), 5'd16);
        send_item(agc_pkg::ACT_FIN, rand_block(), 5'd16);
        // Full message with extreme data and odd byte counts
        send_item(agc_pkg::ACT_START, {128{1'b1}}, 5'd0);
        send_item(agc_pkg::ACT_AAD, {128{1'b1}}, 5'd0);
        send_item(agc_pkg::ACT_AAD, {128{1'b0}}, 5'd16);
        send_item(agc_pkg::ACT_AAD, {128{1'b1}}, 5'd5);
        send_item(agc_pkg::ACT_AAD, rand_block(), 5'd16);
        send_item(agc_pkg::ACT_TEXT, {128{1'b1}}, 5'd31);
        send_item(agc_pkg::ACT_TEXT, {128{1'b0}}, 5'd17);
        send_item(agc_pkg::ACT_TEXT, rand_block(), 5'd1);
        send_item(agc_pkg::ACT_TEXT, rand_block(), 5'd16);
        send_finish(1'b0);
        // Restart in mid message
        send_item(agc_pkg::ACT_START, rand_block(), 5'd16);
        send_item(agc_pkg::ACT_TEXT, rand_block(), 5'd8);
        send_item(agc_pkg::ACT_START, {128{1'b0}}, 5'd31);
        send_item(agc_pkg::ACT_TEXT, rand_block(), 5'd15);
        send_finish(1'b0);
        // Open with a right tag, then a wrong one
        set_config({128{1'b1}}, DIR_OPEN);
        send_item(agc_pkg::ACT_START, rand_block(), 5'd16);
        send_item(agc_pkg::ACT_AAD, rand_block(), 5'd9);
        send_item(agc_pkg::ACT_TEXT, rand_block(), 5'd16);
        send_finish(1'b1);
        send_item(agc_pkg::ACT_START, rand_block(), 5'd16);
        send_item(agc_pkg::ACT_TEXT, rand_block(), 5'd7);
        send_finish(1'b0);
    endtask

    task automatic test_random(input int target);
        int p;
        while (items_sent < target) begin
            if ($urandom_range(0, 5) == 0) begin
                p = $urandom_range(0, 3);
                set_config(p == 0 ? {128{1'b0}} : p == 1 ? {128{1'b1}} : rand_block(),
                           1'($urandom_range(0, 1)));
            end
            calm = ($urandom_range(0, 7) == 0);
            p = $urandom_range(0, 99);
            if (p < 80) begin
                send_message(4);
            end else if (p < 90) begin
                // noise item, any field value
                send_item(2'($urandom_range(0, 3)), rand_block(), 5'($urandom_range(0, 31)));
            end else begin
                // broken message: cut short or restarted
                send_item(agc_pkg::ACT_START, rand_block(), 5'd16);
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(1, 2)), rand_block(), 5'($urandom_range(0, 20)));
            end
        end
        calm = 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering text
    task automatic test_backpressure();
        set_config(rand_block(), DIR_SEAL);
        send_item(agc_pkg::ACT_START, rand_block(), 5'd16);
        hold_left = 400;
        calm = 1'b1;
        repeat (12) send_item(agc_pkg::ACT_TEXT, rand_block(), 5'd16);
        send_finish(1'b0);
        calm = 1'b0;
        drain();
    endtask

    initial begin
        errors = 0; items_sent = 0; results_seen = 0; tags_seen = 0; verdicts_true = 0;
        cycle_count = 0; hold_left = 0; stall_left = 0; calm = 1'b0; done = 1'b0;
        phase = MSG_IDLE; cipher_key = '0; open_mode = DIR_SEAL;
        hkey = '0; j0_mask = '0; ctr_block = '0; hash_acc = '0; aad_bits = '0; text_bits = '0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = REG_KEY_UP; i_cfg_data = '0;
        i_valid = 1'b0; i_action = agc_pkg::ACT_START; i_data_upper = '0; i_data_lower = '0;
        i_byte_count = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1300);
        drain();
        $display("covered %0d items and %0d results (%0d tags or verdicts, %0d good verdicts)",
                 items_sent, results_seen, tags_seen, verdicts_true);
        $display("seal and open directions, key extremes, odd byte counts, restarts, long stalls");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/agc_pkg.sv
rtl/core/agc_front.sv
rtl/core/agc_back.sv
rtl/core/aes_gcm_authenticated_cipher.sv
verif/aes_gcm_authenticated_cipher_test.sv
